/* rtl/core/bblru_pkg.sv */
// Shared types and constants for the byte-budget LRU cache core.
// No dependencies; imported by every module of the block.
`default_nettype none
package bblru_pkg;

    localparam int TOTAL_W = 40;
    localparam logic [TOTAL_W-1:0] BUDGET_RESET = 40'd268435456;

    localparam logic [2:0] OP_LOOKUP    = 3'd0;
    localparam logic [2:0] OP_PEEK      = 3'd1;
    localparam logic [2:0] OP_INSERT    = 3'd2;
    localparam logic [2:0] OP_EVICT     = 3'd3;
    localparam logic [2:0] OP_CLEAR_ALL = 3'd4;
    localparam logic [2:0] OP_CLEAR_SES = 3'd5;
    localparam logic [2:0] OP_SET_PIN   = 3'd6;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_MISSING = 2'd1;
    localparam logic [1:0] STAT_REFUSED = 2'd2;

    typedef struct packed {
        logic [2:0]  operation;
        logic [63:0] key;
        logic [31:0] item_size;
        logic [31:0] session_tag;
        logic        pin_flag;
    } bblru_in_t;

    typedef struct packed {
        logic               hit;
        logic [3:0]         slot_index;
        logic [31:0]        found_size;
        logic [1:0]         status;
        logic [TOTAL_W-1:0] bytes_in_use;
        logic [4:0]         evicted_count;
        logic [4:0]         removed_count;
    } bblru_out_t;

    // read-out chain passed from cell to cell
    typedef struct packed {
        logic        match_seen;
        logic        free_seen;
        logic [31:0] rd_size;
    } link_t;

    // command broadcast to all cells; per-cell target select travels separately
    typedef struct packed {
        logic        load;
        logic        drop;
        logic        set_pin;
        logic        pin_val;
        logic        promote;
        logic [31:0] size;
        logic [31:0] session;
    } cell_cmd_t;

    typedef struct packed {
        logic valid;
        logic pinned;
        logic key_hit;
        logic sess_hit;
        logic match_first;
        logic free_first;
        logic at_walk;
    } cell_stat_t;

endpackage
`default_nettype wire

/* rtl/core/bblru_cell.sv */
// One table slot: key, size, session, pin mark and LRU rank.
// Depends on bblru_pkg; chained by the top level through link_t.
`default_nettype none
module bblru_cell
    import bblru_pkg::*;
#(
    parameter int IW  = 4,
    parameter int KW  = 64,
    parameter int IDX = 0
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire link_t         link_in,
    input  wire logic [IW-1:0] rank_in,
    input  wire cell_cmd_t     cmd,
    input  wire logic [KW-1:0] key_in,
    input  wire logic [IW-1:0] promo_rank,
    input  wire logic [IW-1:0] walk_rank,
    input  wire logic          sel_rd,
    input  wire logic          sel_wr,
    output link_t              link_out,
    output logic [IW-1:0]      rank_out,
    output cell_stat_t         stat
);

    logic          valid_reg;
    logic          pinned_reg;
    logic [IW-1:0] rank_reg;
    logic [KW-1:0] key_reg;
    logic [31:0]   size_reg;
    logic [31:0]   sess_reg;

    always_comb begin
        stat.valid       = valid_reg;
        stat.pinned      = pinned_reg;
        stat.key_hit     = valid_reg && (key_reg == key_in);
        stat.sess_hit    = valid_reg && (sess_reg == cmd.session);
        stat.match_first = stat.key_hit && !link_in.match_seen;
        stat.free_first  = !valid_reg && !link_in.free_seen;
        stat.at_walk     = (rank_reg == walk_rank);
        link_out.match_seen = link_in.match_seen | stat.key_hit;
        link_out.free_seen  = link_in.free_seen | !valid_reg;
        link_out.rd_size    = link_in.rd_size | (sel_rd ? size_reg : 32'd0);
        rank_out            = rank_in | (sel_rd ? rank_reg : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            pinned_reg <= 1'b0;
            rank_reg   <= IW'(IDX);
        end else begin
            if (sel_wr && cmd.load) begin
                valid_reg  <= 1'b1;
                pinned_reg <= cmd.pin_val;
            end else if (sel_wr && cmd.drop) begin
                valid_reg  <= 1'b0;
                pinned_reg <= 1'b0;
            end else if (sel_wr && cmd.set_pin) begin
                pinned_reg <= cmd.pin_val;
            end
            if (cmd.promote) begin
                if (sel_wr) begin
                    rank_reg <= '0;
                end else if (rank_reg < promo_rank) begin
                    rank_reg <= rank_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sel_wr && cmd.load) begin
            key_reg  <= key_in;
            size_reg <= cmd.size;
            sess_reg <= cmd.session;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/byte_budget_lru_cache_core.sv */
// Top level of the byte-budget LRU cache: sequencer plus a chain of slot cells.
// Depends on bblru_pkg and bblru_cell.
//
// Usage:
//   s_valid/s_ready/s_data carry one operation per transfer; m_valid/m_ready/m_data
//   return exactly one result per operation. cfg_wr_en/cfg_wr_data write the byte
//   budget in any cycle without handshake.
//   One operation is in flight at a time; s_ready is high only while the sequencer
//   is idle. The result sits in an output register, so the next operation is taken
//   while the previous result still waits.
//   Sequence of states per operation:
//     peek / lookup / set pin: find, then act on a hit; a miss goes to finish.
//     insert: find, then write (through act when the key is replaced), then the
//             eviction walk over ranks from the oldest; a full table first walks
//             the ranks for an unpinned victim before the write.
//     evict pass: the eviction walk, until the total fits or no rank is left.
//     clear all / clear session: a walk over every slot; session tag 0 skips it.
//   The rank and slot walks visit one cell per cycle.
//   Reset empties every slot, sets ranks to slot order, total to zero and the
//   budget to 256 MiB. A stalled receiver holds the result; the sequencer waits
//   in its final state until the output register is free.
`default_nettype none
module byte_budget_lru_cache_core
    import bblru_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire bblru_in_t          s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output bblru_out_t              m_data,
    input  wire logic               cfg_wr_en,
    input  wire logic [TOTAL_W-1:0] cfg_wr_data
);

    localparam int IW = $clog2(ENTRIES);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FIND   = 3'd1;
    localparam logic [2:0] S_ACT    = 3'd2;
    localparam logic [2:0] S_FULLW  = 3'd3;
    localparam logic [2:0] S_WRITE  = 3'd4;
    localparam logic [2:0] S_EVICT  = 3'd5;
    localparam logic [2:0] S_CLR    = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [2:0]          op_reg, op_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [31:0]         size_reg, size_next;
    logic [31:0]         sess_reg, sess_next;
    logic                pin_reg, pin_next;
    logic [ENTRIES-1:0]  sel_reg, sel_next;
    logic [ENTRIES-1:0]  skip_reg, skip_next;
    logic [IW-1:0]       walk_reg, walk_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [TOTAL_W-1:0]  budget_reg;
    logic                hit_reg, hit_next;
    logic [3:0]          slot_reg, slot_next;
    logic [31:0]         fsize_reg, fsize_next;
    logic [1:0]          status_reg, status_next;
    logic [4:0]          evict_reg, evict_next;
    logic [4:0]          rem_reg, rem_next;
    logic                m_valid_reg, m_valid_next;
    bblru_out_t          m_data_reg, m_data_next;

    link_t              link [ENTRIES+1];
    logic [IW-1:0]      rank_ch [ENTRIES+1];
    cell_stat_t         stat [ENTRIES];
    cell_cmd_t          cmd;
    logic [ENTRIES-1:0] rd_sel, wr_sel;
    logic [ENTRIES-1:0] valid_v, pinned_v, sess_v, matchf_v, freef_v, atw_v;
    logic [IW-1:0]      promo_rank;
    logic [31:0]        rd_size;
    logic [IW-1:0]      rd_rank;
    logic [3:0]         sel_slot;
    logic [ENTRIES-1:0] evictable;

    assign link[0]    = '0;
    assign rank_ch[0] = '0;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        bblru_cell #(
            .IW  (IW),
            .KW  (KEY_BITS),
            .IDX (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .link_in    (link[i]),
            .rank_in    (rank_ch[i]),
            .cmd        (cmd),
            .key_in     (key_reg),
            .promo_rank (promo_rank),
            .walk_rank  (walk_reg),
            .sel_rd     (rd_sel[i]),
            .sel_wr     (wr_sel[i]),
            .link_out   (link[i+1]),
            .rank_out   (rank_ch[i+1]),
            .stat       (stat[i])
        );
        assign valid_v[i]  = stat[i].valid;
        assign pinned_v[i] = stat[i].pinned;
        assign sess_v[i]   = stat[i].sess_hit;
        assign matchf_v[i] = stat[i].match_first;
        assign freef_v[i]  = stat[i].free_first;
        assign atw_v[i]    = stat[i].at_walk;
    end

    assign rd_size    = link[ENTRIES].rd_size;
    assign rd_rank    = rank_ch[ENTRIES];
    assign promo_rank = rd_rank;
    assign rd_sel     = (state_reg == S_FULLW || state_reg == S_EVICT) ? atw_v : sel_reg;
    assign evictable  = atw_v & valid_v & ~pinned_v;

    always_comb begin
        sel_slot = 4'd0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (sel_reg[i]) begin
                sel_slot = sel_slot | 4'(i);
            end
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        size_next    = size_reg;
        sess_next    = sess_reg;
        pin_next     = pin_reg;
        sel_next     = sel_reg;
        skip_next    = skip_reg;
        walk_next    = walk_reg;
        total_next   = total_reg;
        hit_next     = hit_reg;
        slot_next    = slot_reg;
        fsize_next   = fsize_reg;
        status_next  = status_reg;
        evict_next   = evict_reg;
        rem_next     = rem_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        cmd          = '0;
        cmd.size     = size_reg;
        cmd.session  = sess_reg;
        cmd.pin_val  = pin_reg;
        wr_sel       = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next     = s_data.operation;
                    key_next    = s_data.key[KEY_BITS-1:0];
                    size_next   = s_data.item_size;
                    sess_next   = s_data.session_tag;
                    pin_next    = s_data.pin_flag;
                    hit_next    = 1'b0;
                    slot_next   = 4'd0;
                    fsize_next  = 32'd0;
                    status_next = STAT_OK;
                    evict_next  = 5'd0;
                    rem_next    = 5'd0;
                    skip_next   = '0;
                    state_next  = S_FIND;
                end
            end
            S_FIND: begin
                walk_next = IW'(ENTRIES - 1);
                case (op_reg)
                    OP_LOOKUP, OP_PEEK, OP_SET_PIN: begin
                        if (|matchf_v) begin
                            sel_next   = matchf_v;
                            hit_next   = 1'b1;
                            state_next = S_ACT;
                        end else begin
                            status_next = STAT_MISSING;
                            state_next  = S_FINISH;
                        end
                    end
                    OP_INSERT: begin
                        if (|matchf_v) begin
                            sel_next   = matchf_v;
                            state_next = S_ACT;
                        end else if (|freef_v) begin
                            sel_next   = freef_v;
                            state_next = S_WRITE;
                        end else begin
                            state_next = S_FULLW;
                        end
                    end
                    OP_EVICT: begin
                        state_next = S_EVICT;
                    end
                    OP_CLEAR_ALL: begin
                        sel_next   = ENTRIES'(1);
                        state_next = S_CLR;
                    end
                    OP_CLEAR_SES: begin
                        sel_next   = ENTRIES'(1);
                        state_next = (sess_reg == 32'd0) ? S_FINISH : S_CLR;
                    end
                    default: begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_ACT: begin
                if (op_reg == OP_INSERT) begin
                    total_next = total_reg - {8'd0, rd_size};
                    state_next = S_WRITE;
                end else begin
                    fsize_next = rd_size;
                    slot_next  = sel_slot;
                    wr_sel     = sel_reg;
                    cmd.promote = (op_reg == OP_LOOKUP);
                    cmd.set_pin = (op_reg == OP_SET_PIN);
                    state_next = S_FINISH;
                end
            end
            S_FULLW: begin
                if (|evictable) begin
                    sel_next   = atw_v;
                    total_next = total_reg - {8'd0, rd_size};
                    evict_next = 5'd1;
                    state_next = S_WRITE;
                end else if (walk_reg == '0) begin
                    status_next = STAT_REFUSED;
                    state_next  = S_FINISH;
                end else begin
                    walk_next = walk_reg - 1'b1;
                end
            end
            S_WRITE: begin
                wr_sel      = sel_reg;
                cmd.load    = 1'b1;
                cmd.promote = 1'b1;
                total_next  = total_reg + {8'd0, size_reg};
                slot_next   = sel_slot;
                skip_next   = sel_reg;
                walk_next   = IW'(ENTRIES - 1);
                state_next  = S_EVICT;
            end
            S_EVICT: begin
                if (total_reg <= budget_reg) begin
                    state_next = S_FINISH;
                end else begin
                    if (|(evictable & ~skip_reg)) begin
                        wr_sel     = atw_v;
                        cmd.drop   = 1'b1;
                        total_next = total_reg - {8'd0, rd_size};
                        evict_next = evict_reg + 1'b1;
                    end
                    if (walk_reg == '0) begin
                        state_next = S_FINISH;
                    end else begin
                        walk_next = walk_reg - 1'b1;
                    end
                end
            end
            S_CLR: begin
                if (|(sel_reg & ((op_reg == OP_CLEAR_ALL) ? valid_v : sess_v))) begin
                    wr_sel     = sel_reg;
                    cmd.drop   = 1'b1;
                    total_next = total_reg - {8'd0, rd_size};
                    rem_next   = rem_reg + 1'b1;
                end
                if (sel_reg[ENTRIES-1]) begin
                    state_next = S_FINISH;
                end else begin
                    sel_next = sel_reg << 1;
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.hit           = hit_reg;
                    m_data_next.slot_index    = slot_reg;
                    m_data_next.found_size    = fsize_reg;
                    m_data_next.status        = status_reg;
                    m_data_next.bytes_in_use  = total_reg;
                    m_data_next.evicted_count = evict_reg;
                    m_data_next.removed_count = rem_reg;
                    state_next                = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            total_reg   <= '0;
            budget_reg  <= BUDGET_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            total_reg   <= total_next;
            if (cfg_wr_en) begin
                budget_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        size_reg   <= size_next;
        sess_reg   <= sess_next;
        pin_reg    <= pin_next;
        sel_reg    <= sel_next;
        skip_reg   <= skip_next;
        walk_reg   <= walk_next;
        hit_reg    <= hit_next;
        slot_reg   <= slot_next;
        fsize_reg  <= fsize_next;
        status_reg <= status_next;
        evict_reg  <= evict_next;
        rem_reg    <= rem_next;
        m_data_reg <= m_data_next;
    end

endmodule
`default_nettype wire

/* rtl/core/bblru_checker.sv */
// Port-level checks for byte_budget_lru_cache_core, bound to the top level.
// Depends on bblru_pkg.
`default_nettype none
module bblru_checker
    import bblru_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire bblru_out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transfer taken while busy");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status != 2'd3)
        else $error("unused status code");

    a_hit_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.hit |-> m_data.status == STAT_OK && m_data.removed_count == 5'd0)
        else $error("hit with bad status");

    a_refused: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STAT_REFUSED |-> !m_data.hit && m_data.evicted_count == 5'd0)
        else $error("refused insert reports evictions");

endmodule

bind byte_budget_lru_cache_core bblru_checker u_bblru_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire

/* tb/tb_byte_budget_lru_cache_core.sv */
// Testbench for byte_budget_lru_cache_core: directed and random operations checked
// against a behavioral cache predictor. Depends on bblru_pkg and the core RTL.
module tb_byte_budget_lru_cache_core;
    timeunit 1ns;
    timeprecision 1ps;
    import bblru_pkg::*;

    localparam int NSLOT = 16;
    localparam int WATCHDOG = 20000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    bblru_in_t s_data;
    logic m_valid;
    logic m_ready;
    bblru_out_t m_data;
    logic cfg_wr_en;
    logic [TOTAL_W-1:0] cfg_wr_data;

    byte_budget_lru_cache_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    // predicted cache contents
    logic [TOTAL_W-1:0] pr_budget;
    logic               pr_valid [NSLOT];
    logic [63:0]        pr_key [NSLOT];
    logic [31:0]        pr_size [NSLOT];
    logic [31:0]        pr_sess [NSLOT];
    logic               pr_pin [NSLOT];
    int                 pr_rank [NSLOT];
    logic [TOTAL_W-1:0] pr_total;

    bblru_out_t expected_results[$];
    int errors = 0;
    int idle_cycles = 0;
    int n_sent = 0;
    int n_results = 0;
    int n_refused = 0;
    int n_evict = 0;
    int rate_mode = 0;
    logic [63:0] key_pool [8];

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int find_slot(logic [63:0] k);
        for (int i = 0; i < NSLOT; i++)
            if (pr_valid[i] && pr_key[i] == k) return i;
        return -1;
    endfunction

    function automatic int slot_of_rank(int r);
        for (int i = 0; i < NSLOT; i++)
            if (pr_rank[i] == r) return i;
        return -1;
    endfunction

    function automatic void make_recent(int s);
        int r;
        r = pr_rank[s];
        for (int i = 0; i < NSLOT; i++)
            if (pr_rank[i] < r) pr_rank[i]++;
        pr_rank[s] = 0;
    endfunction

    function automatic void remove_slot(int s);
        pr_total = pr_total - pr_size[s];
        pr_valid[s] = 1'b0;
        pr_pin[s] = 1'b0;
    endfunction

    function automatic int trim_to_budget(int skip);
        int n;
        int s;
        n = 0;
        for (int r = NSLOT - 1; r >= 0 && pr_total > pr_budget; r--) begin
            s = slot_of_rank(r);
            if (s < 0 || s == skip || !pr_valid[s] || pr_pin[s]) continue;
            remove_slot(s);
            n++;
        end
        return n;
    endfunction

    function automatic void cache_reset();
        pr_budget = BUDGET_RESET;
        for (int i = 0; i < NSLOT; i++) begin
            pr_valid[i] = 0; pr_pin[i] = 0; pr_rank[i] = i;
            pr_key[i] = '0; pr_size[i] = '0; pr_sess[i] = '0;
        end
        pr_total = '0;
    endfunction

    function automatic bblru_out_t predict_cache(bblru_in_t op);
        bblru_out_t r;
        int s;
        int c;
        r = '0;
        case (op.operation)
            OP_LOOKUP, OP_PEEK, OP_SET_PIN: begin
                s = find_slot(op.key);
                if (s < 0) r.status = STAT_MISSING;
                else begin
                    r.hit = 1'b1;
                    r.slot_index = s[3:0];
                    r.found_size = pr_size[s];
                    if (op.operation == OP_LOOKUP) make_recent(s);
                    if (op.operation == OP_SET_PIN) pr_pin[s] = op.pin_flag;
                end
            end
            OP_INSERT: begin
                s = find_slot(op.key);
                if (s >= 0) remove_slot(s);
                for (int i = 0; i < NSLOT && s < 0; i++)
                    if (!pr_valid[i]) s = i;
                if (s < 0) begin
                    for (int k = NSLOT - 1; k >= 0 && s < 0; k--) begin
                        c = slot_of_rank(k);
                        if (c >= 0 && pr_valid[c] && !pr_pin[c]) s = c;
                    end
                    if (s >= 0) begin
                        remove_slot(s);
                        r.evicted_count++;
                    end
                end
                if (s < 0) r.status = STAT_REFUSED;
                else begin
                    pr_valid[s] = 1'b1;
                    pr_key[s] = op.key;
                    pr_size[s] = op.item_size;
                    pr_sess[s] = op.session_tag;
                    pr_pin[s] = op.pin_flag;
                    make_recent(s);
                    pr_total = pr_total + op.item_size;
                    r.evicted_count = r.evicted_count + 5'(trim_to_budget(s));
                    r.slot_index = s[3:0];
                end
            end
            OP_EVICT: r.evicted_count = 5'(trim_to_budget(-1));
            OP_CLEAR_ALL: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (pr_valid[i]) r.removed_count++;
                    pr_valid[i] = 0;
                    pr_pin[i] = 0;
                end
                pr_total = '0;
            end
            OP_CLEAR_SES: begin
                if (op.session_tag != 0)
                    for (int i = 0; i < NSLOT; i++)
                        if (pr_valid[i] && pr_sess[i] == op.session_tag) begin
                            remove_slot(i);
                            r.removed_count++;
                        end
            end
            default: ;
        endcase
        r.bytes_in_use = pr_total;
        return r;
    endfunction

    function automatic int gap_len();
        if (rate_mode == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 1) == 0) return 0;
        return $urandom_range(1, 3);
    endfunction

    task automatic send_op(bblru_in_t op);
        int g;
        g = gap_len();
        repeat (g + 1) @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= op;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(predict_cache(op));
        if (op.operation == OP_INSERT && expected_results[$].status == STAT_REFUSED)
            n_refused++;
        if (expected_results[$].evicted_count != 0) n_evict++;
        n_sent++;
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic drain();
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_budget(logic [TOTAL_W-1:0] v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        pr_budget = v;
    endtask

    function automatic bblru_in_t mk(logic [2:0] o, logic [63:0] k, logic [31:0] sz,
                                     logic [31:0] se, logic p);
        bblru_in_t t;
        t.operation = o; t.key = k; t.item_size = sz; t.session_tag = se; t.pin_flag = p;
        return t;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                bblru_out_t e;
                e = expected_results.pop_front();
                n_results++;
                if (m_data.hit !== e.hit) begin
                    $error("hit exp %0h got %0h", e.hit, m_data.hit); errors++;
                end
                if (m_data.slot_index !== e.slot_index) begin
                    $error("slot_index exp %0h got %0h", e.slot_index, m_data.slot_index);
                    errors++;
                end
                if (m_data.found_size !== e.found_size) begin
                    $error("found_size exp %0h got %0h", e.found_size, m_data.found_size);
                    errors++;
                end
                if (m_data.status !== e.status) begin
                    $error("status exp %0h got %0h", e.status, m_data.status); errors++;
                end
                if (m_data.bytes_in_use !== e.bytes_in_use) begin
                    $error("bytes_in_use exp %0h got %0h", e.bytes_in_use,
                           m_data.bytes_in_use);
                    errors++;
                end
                if (m_data.evicted_count !== e.evicted_count) begin
                    $error("evicted_count exp %0h got %0h", e.evicted_count,
                           m_data.evicted_count);
                    errors++;
                end
                if (m_data.removed_count !== e.removed_count) begin
                    $error("removed_count exp %0h got %0h", e.removed_count,
                           m_data.removed_count);
                    errors++;
                end
            end
        end
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rate_mode == 0) m_ready <= 1'b1;
            else if ($urandom_range(0, 29) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(negedge aclk);
            end else m_ready <= ($urandom_range(0, 2) != 0);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic test_directed();
        send_op(mk(OP_LOOKUP, 64'h0, 0, 0, 0));
        send_op(mk(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
        send_op(mk(OP_INSERT, 64'h0, 0, 0, 0));
        send_op(mk(OP_PEEK, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0));
        send_op(mk(OP_LOOKUP, 64'h0, 0, 0, 0));
        send_op(mk(OP_INSERT, 64'h0, 32'h1234, 5, 0));
        send_op(mk(OP_SET_PIN, 64'h0, 0, 0, 1));
        send_op(mk(OP_SET_PIN, 64'h77, 0, 0, 1));
        send_op(mk(OP_EVICT, 0, 0, 0, 0));
        send_op(mk(OP_SET_PIN, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0));
        send_op(mk(OP_EVICT, 0, 0, 0, 0));
        send_op(mk(OP_CLEAR_SES, 0, 0, 0, 0));
        send_op(mk(OP_CLEAR_SES, 0, 0, 5, 0));
        send_op(mk(3'd7, 64'h5, 1, 1, 1));
        send_op(mk(OP_CLEAR_ALL, 0, 0, 0, 0));
    endtask

    task automatic test_full_table();
        for (int i = 0; i < NSLOT; i++)
            send_op(mk(OP_INSERT, 64'(i + 100), 32'(i + 1), 32'(i & 1), 1));
        send_op(mk(OP_INSERT, 64'h999, 9, 0, 0));
        send_op(mk(OP_SET_PIN, 64'd103, 0, 0, 0));
        send_op(mk(OP_INSERT, 64'h999, 9, 0, 0));
        send_op(mk(OP_CLEAR_SES, 0, 0, 1, 0));
        send_op(mk(OP_CLEAR_ALL, 0, 0, 0, 0));
    endtask

    task automatic test_random(int count);
        bblru_in_t op;
        int w;
        for (int n = 0; n < count; n++) begin
            if (n % 300 == 299) drain();
            w = $urandom_range(0, 99);
            op.key = ($urandom_range(0, 9) == 0) ? rand64() : key_pool[$urandom_range(0, 7)];
            op.item_size = ($urandom_range(0, 9) == 0) ? $urandom() :
                           32'($urandom_range(0, 2000));
            op.session_tag = ($urandom_range(0, 9) == 0) ? $urandom() :
                             32'($urandom_range(0, 3));
            op.pin_flag = ($urandom_range(0, 4) == 0);
            if (w < 40) op.operation = OP_INSERT;
            else if (w < 55) op.operation = OP_LOOKUP;
            else if (w < 65) op.operation = OP_PEEK;
            else if (w < 78) op.operation = OP_SET_PIN;
            else if (w < 88) op.operation = OP_EVICT;
            else if (w < 95) op.operation = OP_CLEAR_SES;
            else if (w < 98) op.operation = OP_CLEAR_ALL;
            else op.operation = 3'd7;
            send_op(op);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        cache_reset();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < 8; i++) key_pool[i] = rand64();
        test_directed();
        write_budget('0);
        test_full_table();
        rate_mode = 1;
        write_budget(40'd5000);
        test_random(600);
        write_budget(40'hFF_FFFF_FFFF);
        test_random(300);
        write_budget(40'd800);
        test_random(600);
        write_budget('0);
        test_random(200);
        write_budget(40'd3000);
        test_random(200);
        drain();
        $display("Sent %0d operations, checked %0d results; %0d evicting, %0d refused.",
                 n_sent, n_results, n_evict, n_refused);
        $display("Budgets covered: zero, small, reset value and maximum.");
        if (errors == 0 && expected_results.size() == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule
